// ===== sv/sfr_pkg.sv =====
// sfr_pkg: shared types, constants and helpers for the stream find/replace block
// used by sfr_cell, sfr_ctrl, sfr_out and stream_find_replace_top; no dependencies
package sfr_pkg;

   // default sizes of the held run and the replacement
   localparam int PATTERN_MAX_DEF = 8;
   localparam int REPLACE_MAX_DEF = 8;

   // field and register widths
   localparam int BYTE_W    = 8;
   localparam int REG_W     = 64;
   localparam int REG_BYTES = REG_W / BYTE_W;
   localparam int REG_SEL_W = $clog2(REG_BYTES);
   localparam int LEN_W     = 4;
   localparam int POS_W     = 5;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_BYTES      = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREFLUSH,
      ST_CHECK,
      ST_REPL,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   // control handed to every cell of the chain
   typedef struct packed {
      logic              append;
      logic              shift;
      logic [BYTE_W-1:0] data;
   } cell_ctl_type;

   // one byte toward the output stage, or the end of an item
   typedef struct packed {
      logic              push;
      logic              finish;
      logic [BYTE_W-1:0] data;
   } emit_type;

   // output stage status back to the sequencer
   typedef struct packed {
      logic slot_free;
      logic fin_ok;
   } out_status_type;

   // byte at a position of a 64-bit register, zero beyond its end
   function automatic logic [BYTE_W-1:0] byte_sel(input logic [REG_W-1:0] word,
                                                  input logic [POS_W-1:0] pos);
      logic [BYTE_W-1:0] result;
      result = '0;
      if (pos < POS_W'(REG_BYTES)) begin
         result = word[{pos[REG_SEL_W-1:0], 3'b000} +: BYTE_W];
      end
      return result;
   endfunction

endpackage

// ===== sv/sfr_cell.sv =====
// sfr_cell: one position of the held run, with its compare against the pattern
// depends on sfr_pkg
module sfr_cell #(
   parameter int IDX = 0,
   parameter int CW  = 4
) (
   input  logic                      clock,
   input  sfr_pkg::cell_ctl_type     ctl,
   input  logic [CW-1:0]             count,
   input  logic [sfr_pkg::BYTE_W-1:0] next_byte,
   input  logic [sfr_pkg::BYTE_W-1:0] pat_byte,
   output logic [sfr_pkg::BYTE_W-1:0] held_byte,
   output logic                      mismatch
);

   logic [sfr_pkg::BYTE_W-1:0] byte_ff;
   logic [sfr_pkg::BYTE_W-1:0] byte_in;
   logic                       valid;

   // this cell holds a byte while its position is below the fill count
   assign valid = (CW'(IDX) < count);

   // load a new byte at the tail, or take the neighbor's byte on release
   always_comb begin
      byte_in = byte_ff;
      if (ctl.append && (count == CW'(IDX))) begin
         byte_in = ctl.data;
      end else if (ctl.shift) begin
         byte_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign held_byte = byte_ff;
   assign mismatch  = valid && (byte_ff != pat_byte);

endmodule

// ===== sv/sfr_out.sv =====
// sfr_out: one-byte holding stage and output register of the result channel
// depends on sfr_pkg
module sfr_out (
   input  logic                        clock,
   input  logic                        reset,
   input  sfr_pkg::emit_type           emit,
   output sfr_pkg::out_status_type     ost,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [sfr_pkg::BYTE_W-1:0]  rsp_tdata,   // [7:0] out_byte
   output logic                        rsp_tlast    // last_of_run
);

   logic                       pend_valid_ff, pend_valid_in;
   logic [sfr_pkg::BYTE_W-1:0] pend_byte_ff, pend_byte_in;
   logic                       out_valid_ff, out_valid_in;
   logic [sfr_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic                       out_last_ff, out_last_in;
   logic                       slot_free;
   logic                       load_out;

   // output register can take a beat this cycle
   assign slot_free     = !out_valid_ff || rsp_tready;
   assign ost.slot_free = slot_free;
   assign ost.fin_ok    = !pend_valid_ff || slot_free;

   // the held byte moves out when a newer one arrives or the item ends
   assign load_out = (emit.push || emit.finish) && pend_valid_ff;

   always_comb begin
      out_valid_in  = load_out || (out_valid_ff && !rsp_tready);
      out_byte_in   = load_out ? pend_byte_ff : out_byte_ff;
      out_last_in   = load_out ? emit.finish : out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      if (emit.push) begin
         pend_valid_in = 1'b1;
         pend_byte_in  = emit.data;
      end else if (emit.finish) begin
         pend_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sv/sfr_ctrl.sv =====
// sfr_ctrl: sequencer that appends, releases, replaces and flushes the held run
// depends on sfr_pkg; drives the sfr_cell chain and the sfr_out stage
module sfr_ctrl #(
   parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF,
   parameter int CW          = $clog2(PATTERN_MAX + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sfr_pkg::BYTE_W-1:0]    req_byte,
   input  logic                          req_eol,
   input  logic [sfr_pkg::LEN_W-1:0]     plen_raw,
   input  logic [sfr_pkg::LEN_W-1:0]     rlen_raw,
   input  logic [sfr_pkg::REG_W-1:0]     repl_bytes,
   input  logic                          any_mismatch,
   input  logic [sfr_pkg::BYTE_W-1:0]    head_byte,
   input  sfr_pkg::out_status_type       ost,
   output sfr_pkg::cell_ctl_type         cell_ctl,
   output logic [CW-1:0]                 count,
   output sfr_pkg::emit_type             emit
);

   localparam int RLW = $clog2(REPLACE_MAX + 1);
   localparam int RIW = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
   localparam logic [CW-1:0] FULL = CW'(PATTERN_MAX);

   sfr_pkg::state_type         state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [RIW-1:0]             ridx_ff, ridx_in;
   logic                       eol_ff, eol_in;
   logic [sfr_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic [CW-1:0]              plen;
   logic [RLW-1:0]             rlen;
   logic                       over_len;
   logic                       at_match;
   logic                       check_done;
   logic                       last_repl;
   logic                       accept;

   // effective lengths: zero pattern length counts as one, both saturate
   always_comb begin
      if (plen_raw == '0) begin
         plen = CW'(1);
      end else if (32'(plen_raw) > PATTERN_MAX) begin
         plen = CW'(PATTERN_MAX);
      end else begin
         plen = CW'(plen_raw);
      end
      if (32'(rlen_raw) > REPLACE_MAX) begin
         rlen = RLW'(REPLACE_MAX);
      end else begin
         rlen = RLW'(rlen_raw);
      end
   end

   // decisions on the held run
   assign accept     = req_tvalid && req_tready;
   assign over_len   = count_ff > plen;
   assign at_match   = !over_len && !any_mismatch && (count_ff == plen);
   assign check_done = !over_len && !any_mismatch &&
                       ((at_match && (rlen == '0)) ||
                        (!at_match && !(eol_ff && (count_ff != '0))));
   assign last_repl  = (RLW'(ridx_ff) + RLW'(1)) == rlen;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfr_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (count_ff == FULL) ? sfr_pkg::ST_PREFLUSH : sfr_pkg::ST_CHECK;
            end
         end
         sfr_pkg::ST_PREFLUSH: begin
            if (count_ff == '0) begin
               state_in = sfr_pkg::ST_CHECK;
            end
         end
         sfr_pkg::ST_CHECK: begin
            priority if (over_len) begin
               state_in = sfr_pkg::ST_FLUSH;
            end else if (any_mismatch) begin
               state_in = sfr_pkg::ST_CHECK;
            end else if (at_match && (rlen != '0)) begin
               state_in = sfr_pkg::ST_REPL;
            end else if (check_done) begin
               state_in = ost.fin_ok ? sfr_pkg::ST_IDLE : sfr_pkg::ST_FINISH;
            end else begin
               state_in = sfr_pkg::ST_FLUSH;
            end
         end
         sfr_pkg::ST_REPL: begin
            if (ost.slot_free && last_repl) begin
               state_in = sfr_pkg::ST_FINISH;
            end
         end
         sfr_pkg::ST_FLUSH: begin
            if ((count_ff == '0) || (ost.slot_free && (count_ff == CW'(1)))) begin
               state_in = sfr_pkg::ST_FINISH;
            end
         end
         sfr_pkg::ST_FINISH: begin
            if (ost.fin_ok) begin
               state_in = sfr_pkg::ST_IDLE;
            end
         end
         default: state_in = sfr_pkg::ST_IDLE;
      endcase
   end

   // outputs to the cells and the output stage
   always_comb begin
      req_tready = 1'b0;
      cell_ctl   = '{append: 1'b0, shift: 1'b0, data: byte_ff};
      emit       = '{push: 1'b0, finish: 1'b0, data: head_byte};
      unique case (state_ff)
         sfr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (count_ff != FULL)) begin
               cell_ctl.append = 1'b1;
               cell_ctl.data   = req_byte;
            end
         end
         sfr_pkg::ST_PREFLUSH: begin
            if (count_ff == '0) begin
               cell_ctl.append = 1'b1;
            end else if (ost.slot_free) begin
               emit.push      = 1'b1;
               cell_ctl.shift = 1'b1;
            end
         end
         sfr_pkg::ST_CHECK: begin
            if (!over_len && any_mismatch && ost.slot_free) begin
               emit.push      = 1'b1;
               cell_ctl.shift = 1'b1;
            end
            if (check_done && ost.fin_ok) begin
               emit.finish = 1'b1;
            end
         end
         sfr_pkg::ST_REPL: begin
            emit.data = sfr_pkg::byte_sel(repl_bytes, sfr_pkg::POS_W'(ridx_ff));
            emit.push = ost.slot_free;
         end
         sfr_pkg::ST_FLUSH: begin
            if ((count_ff != '0) && ost.slot_free) begin
               emit.push      = 1'b1;
               cell_ctl.shift = 1'b1;
            end
         end
         sfr_pkg::ST_FINISH: begin
            emit.finish = ost.fin_ok;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // fill count, replacement index and the latched input beat
   always_comb begin
      count_in = count_ff;
      if (cell_ctl.append) begin
         count_in = count_ff + CW'(1);
      end else if (cell_ctl.shift) begin
         count_in = count_ff - CW'(1);
      end
      if ((state_ff == sfr_pkg::ST_CHECK) && at_match) begin
         count_in = '0;
      end
      ridx_in = ridx_ff;
      if (state_ff == sfr_pkg::ST_CHECK) begin
         ridx_in = '0;
      end else if ((state_ff == sfr_pkg::ST_REPL) && emit.push) begin
         ridx_in = ridx_ff + RIW'(1);
      end
      eol_in  = accept ? req_eol : eol_ff;
      byte_in = accept ? req_byte : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfr_pkg::ST_IDLE;
         count_ff <= '0;
         eol_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         eol_ff   <= eol_in;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff <= ridx_in;
      byte_ff <= byte_in;
   end

   assign count = count_ff;

   // fill count never passes the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("held run count beyond chain length");

   // a byte is only handed over when the output register can take it
   a_push_slot: assert property (@(posedge clock) disable iff (reset)
      emit.push |-> ost.slot_free)
      else $error("byte pushed while output register is blocked");

   // an accepted item always keeps the sequencer busy for the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != sfr_pkg::ST_IDLE))
      else $error("sequencer idle right after accepting a beat");

   // replacement index stays inside the replacement
   a_repl_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfr_pkg::ST_REPL) |-> (RLW'(ridx_ff) < rlen))
      else $error("replacement index out of range");

   // the chain never appends and releases in the same cycle
   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(cell_ctl.append && cell_ctl.shift))
      else $error("append and shift at once");

endmodule

// ===== sv/stream_find_replace_top.sv =====
// stream_find_replace_top: streaming find and replace on a byte stream
// depends on sfr_pkg, sfr_cell, sfr_ctrl and sfr_out
//
// Input beats on req_* carry one text byte and an end-of-line flag. Every
// leftmost, non-overlapping occurrence of the pattern (csr registers 0 and 1)
// is replaced by the replacement (registers 2 and 3, length zero deletes).
// Bytes that may still start a match wait in a chain of cells, one byte per
// cell; a run that stops matching releases bytes from its front. An
// end-of-line beat flushes everything held after its own byte.
// Result beats on rsp_* carry one byte each; rsp_tlast marks the final result
// of an input beat. A beat causing no result produces nothing.
// The sequencer moves one byte per cycle while the output register can take
// a beat, so an input beat occupies it longer the more results it causes.
// The newest result waits in a one-byte holding stage until its successor or
// the end of the item is known. A stall on rsp_tready holds the sequencer
// wherever it would move a byte out; no beat is lost. Reset (synchronous)
// empties the held run and loads the register defaults; config writes belong
// between items, while no beat is in flight.
module stream_find_replace_top #(
   parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sfr_pkg::BYTE_W-1:0]      req_tdata,   // [7:0] data_byte
   input  logic                            req_tlast,   // end_of_line
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sfr_pkg::BYTE_W-1:0]      rsp_tdata,   // [7:0] out_byte
   output logic                            rsp_tlast,   // last_of_run
   // configuration writes
   input  logic                            csr_wr_en,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfr_pkg::REG_W-1:0]       csr_wr_data
);

   localparam int CW = $clog2(PATTERN_MAX + 1);

   logic [sfr_pkg::REG_W-1:0] pattern_ff, pattern_in;
   logic [sfr_pkg::LEN_W-1:0] plen_ff, plen_in;
   logic [sfr_pkg::REG_W-1:0] repl_ff, repl_in;
   logic [sfr_pkg::LEN_W-1:0] rlen_ff, rlen_in;

   sfr_pkg::cell_ctl_type      cell_ctl;
   sfr_pkg::emit_type          emit;
   sfr_pkg::out_status_type    ost;
   logic [CW-1:0]              count;
   logic [sfr_pkg::BYTE_W-1:0] held [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]     mismatch;

   // configuration registers
   always_comb begin
      pattern_in = pattern_ff;
      plen_in    = plen_ff;
      repl_in    = repl_ff;
      rlen_in    = rlen_ff;
      if (csr_wr_en) begin
         unique case (sfr_pkg::csr_index_type'(csr_index))
            sfr_pkg::CSR_PATTERN_BYTES:      pattern_in = csr_wr_data;
            sfr_pkg::CSR_PATTERN_LENGTH:     plen_in    = csr_wr_data[sfr_pkg::LEN_W-1:0];
            sfr_pkg::CSR_REPLACEMENT_BYTES:  repl_in    = csr_wr_data;
            sfr_pkg::CSR_REPLACEMENT_LENGTH: rlen_in    = csr_wr_data[sfr_pkg::LEN_W-1:0];
            default:                         pattern_in = pattern_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         plen_ff    <= sfr_pkg::LEN_W'(1);
         repl_ff    <= '0;
         rlen_ff    <= '0;
      end else begin
         pattern_ff <= pattern_in;
         plen_ff    <= plen_in;
         repl_ff    <= repl_in;
         rlen_ff    <= rlen_in;
      end
   end

   // chain of cells holding the run, each compared with its pattern byte
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      logic [sfr_pkg::BYTE_W-1:0] next_byte;
      if (i == PATTERN_MAX - 1) begin : g_tail
         assign next_byte = '0;
      end else begin : g_body
         assign next_byte = held[i+1];
      end
      sfr_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .count     (count),
         .next_byte (next_byte),
         .pat_byte  (sfr_pkg::byte_sel(pattern_ff, sfr_pkg::POS_W'(i))),
         .held_byte (held[i]),
         .mismatch  (mismatch[i])
      );
   end

   sfr_ctrl #(
      .PATTERN_MAX (PATTERN_MAX),
      .REPLACE_MAX (REPLACE_MAX),
      .CW          (CW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_byte     (req_tdata),
      .req_eol      (req_tlast),
      .plen_raw     (plen_ff),
      .rlen_raw     (rlen_ff),
      .repl_bytes   (repl_ff),
      .any_mismatch (|mismatch),
      .head_byte    (held[0]),
      .ost          (ost),
      .cell_ctl     (cell_ctl),
      .count        (count),
      .emit         (emit)
   );

   sfr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .ost        (ost),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
